### design/sfcd_pkg.sv
// Package for the serial frame checksum deframer.
// Holds the frame constants, status codes and the result record type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package sfcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 9;
    localparam int STATUS_W = 2;

    // Total bytes of a fixed frame, checksum byte included.
    localparam int FIXED_FRAME_BYTES = 64;
    // Header bytes, length byte and checksum byte around the payload.
    localparam int EXTRA_BYTES = 4;

    localparam logic [BYTE_W-1:0] HDR_A = 8'hFE;
    localparam logic [BYTE_W-1:0] HDR_B = 8'hEF;

    localparam logic [POS_W-1:0] POS_HDR0 = 9'd0;
    localparam logic [POS_W-1:0] POS_HDR1 = 9'd1;
    localparam logic [POS_W-1:0] POS_LEN  = 9'd2;

    localparam logic [POS_W-1:0] FIXED_CSUM_POS = POS_W'(FIXED_FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] LEN_CSUM_ADD   = POS_W'(EXTRA_BYTES - 1);
    // Largest offset a frame can reach.
    localparam logic [POS_W-1:0] MAX_POS =
        (FIXED_FRAME_BYTES - 1 > 255 + EXTRA_BYTES - 1) ? POS_W'(FIXED_FRAME_BYTES - 1)
                                                        : POS_W'(255 + EXTRA_BYTES - 1);

    localparam logic [STATUS_W-1:0] STATUS_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_GOOD   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [POS_W-1:0]    frame_pos;
        logic                frame_kind;
        logic                frame_end;
        logic [STATUS_W-1:0] frame_status;
    } sfcd_result_t;

endpackage

`default_nettype wire

### design/sfcd_if.sv
// Stream interfaces of the deframer: received bytes in, annotated bytes out.
// Each carries valid, ready and the payload. Depends on sfcd_pkg.
`default_nettype none

interface sfcd_in_if
    import sfcd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcd_out_if
    import sfcd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic [POS_W-1:0]    frame_pos;
    logic                frame_kind;
    logic                frame_end;
    logic [STATUS_W-1:0] frame_status;

    modport source (output valid, output out_byte, output frame_pos, output frame_kind,
                    output frame_end, output frame_status, input ready);
    modport sink   (input valid, input out_byte, input frame_pos, input frame_kind,
                    input frame_end, input frame_status, output ready);
endinterface

`default_nettype wire

### design/serial_frame_checksum_deframer.sv
// Serial frame checksum deframer, top level. Takes one received byte per
// request and returns it tagged with its frame offset, frame kind and, on the
// checksum byte, a good/bad verdict. A frame whose two header bytes are FE EF
// or EF FE is 64 bytes long; any other frame is its length byte (third byte)
// plus 4. The checksum is the inverted low byte of the length byte plus the
// payload. Exactly one result comes out for every byte taken, in order. The
// block takes one byte every cycle while the output is not stalled; a taken
// byte sits in the input register, moves into the result register when that
// register can load and is offered on the output from then on. The tracker
// between the registers does a compare, an 8-bit add and the offset count.
// Both registers hand off in the same cycle, so a stalled output backs up
// through at most two held bytes. Depends on sfcd_pkg and sfcd_if.
`default_nettype none

module serial_frame_checksum_deframer
    import sfcd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfcd_in_if.sink    in_ch,
    sfcd_out_if.source out_ch
);

    logic              advance;
    logic              stage_valid;
    logic [BYTE_W-1:0] stage_byte;
    sfcd_result_t      result;

    sfcd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (in_ch),
        .advance (advance),
        .valid   (stage_valid),
        .rx_byte (stage_byte)
    );

    sfcd_frame_logic u_frame_logic (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (stage_byte),
        .result  (result)
    );

    sfcd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid),
        .result   (result),
        .advance  (advance),
        .tx       (out_ch)
    );

endmodule

`default_nettype wire

### design/sfcd_in_stage.sv
// Input register of the deframer: captures one received byte per request.
// Depends on sfcd_pkg and sfcd_in_if.
`default_nettype none

module sfcd_in_stage
    import sfcd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    sfcd_in_if.sink        rx,
    input  wire logic      advance,
    output logic           valid,
    output logic [BYTE_W-1:0] rx_byte
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    // Accept when empty or when the held byte moves on this cycle.
    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign valid   = valid_reg;
    assign rx_byte = byte_reg;

endmodule

`default_nettype wire

### design/sfcd_frame_logic.sv
// Frame tracker: position, header kind, length and running checksum state,
// plus the combinational annotation of the current byte. Depends on sfcd_pkg.
`default_nettype none

module sfcd_frame_logic
    import sfcd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output sfcd_result_t      result
);

    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [BYTE_W-1:0] hdr0_reg,   hdr0_next;
    logic              fixed_reg,  fixed_next;
    logic [BYTE_W-1:0] len_reg,    len_next;
    logic [BYTE_W-1:0] sum_reg,    sum_next;

    logic [POS_W-1:0]  csum_pos;
    logic              is_fixed_hdr;
    logic              at_csum;

    assign is_fixed_hdr = (hdr0_reg == HDR_A && rx_byte == HDR_B) ||
                          (hdr0_reg == HDR_B && rx_byte == HDR_A);
    assign csum_pos = fixed_reg ? FIXED_CSUM_POS
                                : ({{(POS_W-BYTE_W){1'b0}}, len_reg} + LEN_CSUM_ADD);
    assign at_csum  = (pos_reg > POS_LEN) && (pos_reg == csum_pos);

    always_comb
    begin
        pos_next   = pos_reg;
        hdr0_next  = hdr0_reg;
        fixed_next = fixed_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;

        result.out_byte     = rx_byte;
        result.frame_pos    = pos_reg;
        result.frame_kind   = fixed_reg;
        result.frame_end    = 1'b0;
        result.frame_status = STATUS_INSIDE;

        if (pos_reg == POS_HDR0)
        begin
            hdr0_next         = rx_byte;
            result.frame_kind = 1'b0;
            pos_next          = POS_HDR1;
        end
        else if (pos_reg == POS_HDR1)
        begin
            fixed_next        = is_fixed_hdr;
            result.frame_kind = is_fixed_hdr;
            pos_next          = POS_LEN;
        end
        else if (pos_reg == POS_LEN)
        begin
            len_next = rx_byte;
            sum_next = rx_byte;
            pos_next = POS_W'(3);
        end
        else if (at_csum)
        begin
            result.frame_end    = 1'b1;
            result.frame_status = (~sum_reg == rx_byte) ? STATUS_GOOD : STATUS_BAD;
            pos_next            = POS_HDR0;
        end
        else
        begin
            sum_next = sum_reg + rx_byte;
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // Commit the state only when the byte moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hdr0_reg  <= '0;
            fixed_reg <= 1'b0;
            len_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            hdr0_reg  <= hdr0_next;
            fixed_reg <= fixed_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
        end
    end

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.frame_end |=> pos_reg == POS_HDR0)
        else $error("frame did not restart after checksum byte");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("frame offset beyond longest frame");

    a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pos_reg) && $stable(sum_reg))
        else $error("frame state moved without a request");

    a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.frame_end == (result.frame_status != STATUS_INSIDE))
        else $error("end flag and status disagree");

endmodule

`default_nettype wire

### design/sfcd_out_stage.sv
// Result register of the deframer: holds one annotated byte until taken.
// Depends on sfcd_pkg and sfcd_out_if.
`default_nettype none

module sfcd_out_stage
    import sfcd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire sfcd_result_t result,
    output logic              advance,
    sfcd_out_if.source        tx
);

    logic         valid_reg;
    logic         valid_next;
    sfcd_result_t res_reg;
    logic         can_load;

    // Load when empty or when the held result is taken this cycle.
    assign can_load = !valid_reg || tx.ready;
    assign advance  = in_valid && can_load;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign tx.valid        = valid_reg;
    assign tx.out_byte     = res_reg.out_byte;
    assign tx.frame_pos    = res_reg.frame_pos;
    assign tx.frame_kind   = res_reg.frame_kind;
    assign tx.frame_end    = res_reg.frame_end;
    assign tx.frame_status = res_reg.frame_status;

endmodule

`default_nettype wire
